### rtl/bli_pkg.sv
`default_nettype none
package bli_pkg;
    typedef struct packed {
        logic dbz;
        logic clip;
    } bli_flags_t;
endpackage
`default_nettype wire

### rtl/bilinear_interpolator_core.sv
// Bilinear interpolation of signed fixed point values, one query per transfer.
// Latency is set mostly by two chains of one-bit divider cells (x weight, then
// y blend); throughput is one query per cycle and the whole pipeline stalls
// only while the output register is full and not taken.
// Zero grid span gives 0 with divide_by_zero; saturated marks any clipping.
`default_nettype none
module bilinear_interpolator_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // point_x, point_y, grid_x_low, grid_x_high, grid_y_low, grid_y_high,
    // corner_ll, corner_hl, corner_lh, corner_hh
    input  wire logic [10*DATA_WIDTH-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // interpolated, divide_by_zero, saturated, zero fill
    output logic [((DATA_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    import bli_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int W2  = 2*W;
    localparam int DVW = W + 1;
    localparam int NX  = W + 1 + FRAC_BITS + 1;
    localparam int NY  = 4*W + 4;
    localparam int OB  = ((W+2+7)/8)*8;
    localparam int D1  = NX + 1;
    localparam int D2  = NY + 1;
    localparam int LAT = D1 + 6 + D2;
    localparam int PW  = W2 + W + 1;
    localparam int LW  = 2*W + 2;
    localparam int HW  = 2*W + 1;
    localparam int GW  = 2*W + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [W-1:0] out_reg;
    logic [1:0]   oflag_reg;
    logic         ovalid_reg;

    assign en       = !ovalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OB'({oflag_reg[0], oflag_reg[1], out_reg});

    function automatic logic signed [W-1:0] fld(input logic [10*W-1:0] d, input int k);
        return d[k*W +: W];
    endfunction

    function automatic logic signed [W2-1:0] sat2(input logic signed [PW:0] v,
                                                  output logic c);
        logic signed [PW:0] hi, lo;
        hi = (PW+1)'({1'b0, {(W2-1){1'b1}}});
        lo = -hi - 1;
        c  = (v > hi) || (v < lo);
        return (v > hi) ? hi[W2-1:0] : ((v < lo) ? lo[W2-1:0] : v[W2-1:0]);
    endfunction

    // stage 0: differences
    logic signed [W:0] dx0_reg, dy0_reg, nx0_reg, ny0_reg, ex0_reg, ey0_reg;
    logic signed [W-1:0] cll0_reg, clh0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg  <= (W+1)'(fld(s_tdata,3)) - (W+1)'(fld(s_tdata,2));
            dy0_reg  <= (W+1)'(fld(s_tdata,5)) - (W+1)'(fld(s_tdata,4));
            nx0_reg  <= (W+1)'(fld(s_tdata,0)) - (W+1)'(fld(s_tdata,2));
            ny0_reg  <= (W+1)'(fld(s_tdata,1)) - (W+1)'(fld(s_tdata,4));
            ex0_reg  <= (W+1)'(fld(s_tdata,7)) - (W+1)'(fld(s_tdata,6));
            ey0_reg  <= (W+1)'(fld(s_tdata,9)) - (W+1)'(fld(s_tdata,8));
            cll0_reg <= fld(s_tdata,6);
            clh0_reg <= fld(s_tdata,8);
        end
    end

    // x division: magnitude cells, side data carried alongside
    localparam int SX = 1 + 1 + 4*(W+1) + 2*W;
    logic          sx_neg;
    logic [NX-1:0] nx_mag;
    logic [W:0]    dx_mag;
    logic signed [NX-1:0] nx_sh;
    logic [SX-1:0] sx_in, sx_out;
    logic [NX-1:0] ux_q;
    always_comb begin
        nx_sh  = NX'(nx0_reg) <<< FRAC_BITS;
        nx_mag = nx_sh[NX-1] ? NX'(-nx_sh) : nx_sh;
        dx_mag = dx0_reg[W] ? (W+1)'(-dx0_reg) : dx0_reg;
        sx_neg = nx_sh[NX-1] ^ dx0_reg[W];
        sx_in  = {sx_neg, (dx0_reg == '0) || (dy0_reg == '0), dy0_reg, ny0_reg,
                  ex0_reg, ey0_reg, cll0_reg, clh0_reg};
    end
    bli_divider #(.NW(NX), .DW(DVW), .SW(SX)) u_divx (
        .aclk(aclk), .en(en), .num(nx_mag), .den(dx_mag),
        .side_in(sx_in), .quo(ux_q), .side_out(sx_out)
    );

    logic          a_neg, a_dbz;
    logic signed [W:0] a_dy, a_ny, a_ex, a_ey;
    logic signed [W-1:0] a_cll, a_clh;
    assign {a_neg, a_dbz, a_dy, a_ny, a_ex, a_ey, a_cll, a_clh} = sx_out;

    // stage: signed u, saturated to 2W
    logic signed [W2-1:0] u_n;
    logic cu_n;
    always_comb begin
        u_n = sat2(a_neg ? -(PW+1)'(ux_q) : (PW+1)'(ux_q), cu_n);
    end

    logic signed [W2-1:0] u_reg;
    logic signed [W:0] ex1_reg, ey1_reg, dy1_reg, ny1_reg;
    logic signed [W-1:0] cll1_reg, clh1_reg;
    logic dbz1_reg, cu1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_n; cu1_reg <= cu_n;
            ex1_reg  <= a_ex; ey1_reg <= a_ey; dy1_reg <= a_dy; ny1_reg <= a_ny;
            cll1_reg <= a_cll; clh1_reg <= a_clh; dbz1_reg <= a_dbz;
        end
    end

    // partial products of u*(corner diff), low and high halves of u
    logic signed [W:0]   u_lo;
    logic signed [W-1:0] u_hi;
    assign u_lo = {1'b0, u_reg[W-1:0]};
    assign u_hi = u_reg[W2-1:W];

    logic signed [LW-1:0] pl1_reg, pl2_reg;
    logic signed [HW-1:0] ph1_reg, ph2_reg;
    logic signed [W:0] dyp_reg, nyp_reg;
    logic signed [W-1:0] cllp_reg, clhp_reg;
    logic dbzp_reg, cup_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pl1_reg <= LW'(u_lo) * LW'(ex1_reg);
            pl2_reg <= LW'(u_lo) * LW'(ey1_reg);
            ph1_reg <= HW'(u_hi) * HW'(ex1_reg);
            ph2_reg <= HW'(u_hi) * HW'(ey1_reg);
            dyp_reg <= dy1_reg; nyp_reg <= ny1_reg;
            cllp_reg <= cll1_reg; clhp_reg <= clh1_reg; dbzp_reg <= dbz1_reg;
            cup_reg <= cu1_reg;
        end
    end

    // products u*(corner diff)
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [W:0] dy2_reg, ny2_reg;
    logic signed [W-1:0] cll2_reg, clh2_reg;
    logic dbz2_reg, cu2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= (PW'(ph1_reg) <<< W) + PW'(pl1_reg);
            p2_reg <= (PW'(ph2_reg) <<< W) + PW'(pl2_reg);
            dy2_reg <= dyp_reg; ny2_reg <= nyp_reg;
            cll2_reg <= cllp_reg; clh2_reg <= clhp_reg; dbz2_reg <= dbzp_reg;
            cu2_reg <= cup_reg;
        end
    end

    logic signed [W2-1:0] f1_reg, f2_reg;
    logic c12_reg;
    logic signed [W:0] dy3_reg, ny3_reg;
    logic dbz3_reg;
    logic signed [W2-1:0] f1_n, f2_n;
    logic c1_n, c2_n;
    always_comb begin
        f1_n = sat2((PW+1)'(cll2_reg) + (PW+1)'(p1_reg >>> FRAC_BITS), c1_n);
        f2_n = sat2((PW+1)'(clh2_reg) + (PW+1)'(p2_reg >>> FRAC_BITS), c2_n);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_n; f2_reg <= f2_n; c12_reg <= c1_n | c2_n | cu2_reg;
            dy3_reg <= dy2_reg; ny3_reg <= ny2_reg; dbz3_reg <= dbz2_reg;
        end
    end

    // partial products of (f2-f1)*ny, low and high halves of f2-f1
    logic signed [W2:0]   fd;
    logic signed [W:0]    fd_lo, fd_hi;
    logic signed [GW-1:0] gl_reg, gh_reg;
    logic signed [W2-1:0] f1a_reg;
    logic signed [W:0] dya_reg;
    logic dbza_reg, ca_reg;
    always_comb begin
        fd    = (W2+1)'(f2_reg) - (W2+1)'(f1_reg);
        fd_lo = {1'b0, fd[W-1:0]};
        fd_hi = fd[W2:W];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            gl_reg  <= GW'(fd_lo) * GW'(ny3_reg);
            gh_reg  <= GW'(fd_hi) * GW'(ny3_reg);
            f1a_reg <= f1_reg; dya_reg <= dy3_reg; dbza_reg <= dbz3_reg;
            ca_reg  <= c12_reg;
        end
    end

    // (f2-f1)*ny
    logic signed [NY-1:0] g_reg;
    logic signed [W2-1:0] f1b_reg;
    logic signed [W:0] dy4_reg;
    logic dbz4_reg, c4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg   <= (NY'(gh_reg) <<< W) + NY'(gl_reg);
            f1b_reg <= f1a_reg; dy4_reg <= dya_reg; dbz4_reg <= dbza_reg;
            c4_reg  <= ca_reg;
        end
    end

    localparam int SY = 1 + 1 + 1 + W2;
    logic [NY-1:0] g_mag, yq;
    logic [W:0]    dy_mag;
    logic [SY-1:0] sy_in, sy_out;
    always_comb begin
        g_mag  = g_reg[NY-1] ? NY'(-g_reg) : g_reg;
        dy_mag = dy4_reg[W] ? (W+1)'(-dy4_reg) : dy4_reg;
        sy_in  = {g_reg[NY-1] ^ dy4_reg[W], dbz4_reg, c4_reg, f1b_reg};
    end
    bli_divider #(.NW(NY), .DW(DVW), .SW(SY)) u_divy (
        .aclk(aclk), .en(en), .num(g_mag), .den(dy_mag),
        .side_in(sy_in), .quo(yq), .side_out(sy_out)
    );

    logic b_neg, b_dbz, b_c;
    logic signed [W2-1:0] b_f1;
    assign {b_neg, b_dbz, b_c, b_f1} = sy_out;

    logic signed [NY:0] r_reg;
    logic b_dbz_reg, b_c_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg     <= (NY+1)'(b_f1) + (b_neg ? -(NY+1)'(yq) : (NY+1)'(yq));
            b_dbz_reg <= b_dbz; b_c_reg <= b_c;
        end
    end

    logic signed [NY:0] rhi, rlo;
    logic [W-1:0] r_sat;
    logic r_clip;
    bli_flags_t fl;
    always_comb begin
        rhi    = (NY+1)'({1'b0, {(W-1){1'b1}}});
        rlo    = -rhi - 1;
        r_clip = (r_reg > rhi) || (r_reg < rlo);
        r_sat  = (r_reg > rhi) ? rhi[W-1:0] : ((r_reg < rlo) ? rlo[W-1:0] : r_reg[W-1:0]);
        fl.dbz  = b_dbz_reg;
        fl.clip = !b_dbz_reg && (b_c_reg || r_clip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
                ovalid_reg <= vld_reg[LAT-1];
            end
        end
        if (en) begin
            out_reg   <= fl.dbz ? '0 : r_sat;
            oflag_reg <= {fl.dbz, fl.clip};
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline advanced under stall");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(oflag_reg[1] && oflag_reg[0]))
        else $error("dbz and saturated both set");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && oflag_reg[1]) |-> (out_reg == '0))
        else $error("nonzero result on zero span");
endmodule
`default_nettype wire

### rtl/bli_div_cell.sv
`default_nettype none
module bli_div_cell #(
    parameter int NW = 64,
    parameter int DW = 33
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [NW-1:0] q_in,
    input  wire logic [DW:0]   rem_in,
    input  wire logic [DW-1:0] den_in,
    output logic [NW-1:0]      num_out,
    output logic [NW-1:0]      q_out,
    output logic [DW:0]        rem_out,
    output logic [DW-1:0]      den_out
);
    logic [DW+1:0] shifted;
    logic [DW+1:0] diff;
    logic          ge;

    always_comb begin
        shifted = {rem_in, num_in[NW-1]};
        diff    = shifted - {1'b0, 1'b0, den_in};
        ge      = !diff[DW+1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_out <= {num_in[NW-2:0], 1'b0};
            q_out   <= {q_in[NW-2:0], ge};
            rem_out <= ge ? diff[DW:0] : shifted[DW:0];
            den_out <= den_in;
        end
    end
endmodule
`default_nettype wire

### rtl/bli_divider.sv
`default_nettype none
module bli_divider #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int SW = 4
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic [NW-1:0]      quo,
    output logic [SW-1:0]      side_out
);
    logic [NW-1:0] n_a [NW+1];
    logic [NW-1:0] q_a [NW+1];
    logic [DW:0]   r_a [NW+1];
    logic [DW-1:0] d_a [NW+1];
    logic [SW-1:0] s_a [NW+1];

    assign n_a[0] = num;
    assign q_a[0] = '0;
    assign r_a[0] = '0;
    assign d_a[0] = den;
    assign s_a[0] = side_in;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        bli_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .aclk(aclk), .en(en),
            .num_in(n_a[i]), .q_in(q_a[i]), .rem_in(r_a[i]), .den_in(d_a[i]),
            .num_out(n_a[i+1]), .q_out(q_a[i+1]), .rem_out(r_a[i+1]),
            .den_out(d_a[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                s_a[i+1] <= s_a[i];
            end
        end
    end

    assign quo      = q_a[NW];
    assign side_out = s_a[NW];
endmodule
`default_nettype wire

### sim/bilinear_interpolator_core_test.sv
`default_nettype none
module bilinear_interpolator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = 5 * DW + FB + 14;
    localparam int STALL_LIMIT = 5000;

    typedef logic signed [DW-1:0] coord_t;
    typedef logic signed [255:0] wide_t;
    typedef struct {
        coord_t interp;
        logic   dbz;
        logic   clip;
    } blend_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [10*DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;

    bit gaps_on = 1'b1;
    int errors = 0;
    int quiet_cycles = 0;
    blend_t blend_queue[$];

    bilinear_interpolator_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic wide_t clamp(wide_t v, int bits, inout logic clip);
        wide_t top;
        top = wide_t'(1) <<< (bits - 1);
        if (v > top - 1) begin
            clip = 1'b1;
            return top - 1;
        end
        if (v < -top) begin
            clip = 1'b1;
            return -top;
        end
        return v;
    endfunction

    function automatic blend_t blend(logic [10*DW-1:0] d);
        wide_t f[10];
        wide_t dx, dy, nx, ny, u, f1, f2, r;
        blend_t b;
        logic clip;
        for (int i = 0; i < 10; i++) f[i] = coord_t'(d[DW*i +: DW]);
        dx = f[3] - f[2];
        dy = f[5] - f[4];
        nx = f[0] - f[2];
        ny = f[1] - f[4];
        clip = 1'b0;
        if (dx == 0 || dy == 0) begin
            b.interp = '0;
            b.dbz = 1'b1;
            b.clip = 1'b0;
            return b;
        end
        u = clamp((nx <<< FB) / dx, 2 * DW, clip);
        f1 = clamp(f[6] + ((u * (f[7] - f[6])) >>> FB), 2 * DW, clip);
        f2 = clamp(f[8] + ((u * (f[9] - f[8])) >>> FB), 2 * DW, clip);
        r = clamp(f1 + ((f2 - f1) * ny) / dy, DW, clip);
        b.interp = r[DW-1:0];
        b.dbz = 1'b0;
        b.clip = clip;
        return b;
    endfunction

    always @(posedge aclk) begin
        blend_t e;
        if (aresetn && s_tvalid && s_tready) blend_queue.push_back(blend(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (blend_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_tdata);
            end else begin
                e = blend_queue.pop_front();
                if (m_tdata[DW-1:0] !== e.interp) begin
                    errors++;
                    $display("%0t: interpolated expected %h actual %h",
                             $time, e.interp, m_tdata[DW-1:0]);
                end
                if (m_tdata[DW] !== e.dbz) begin
                    errors++;
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, e.dbz, m_tdata[DW]);
                end
                if (m_tdata[DW+1] !== e.clip) begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, e.clip, m_tdata[DW+1]);
                end
                if (m_tdata[39:DW+2] !== '0) begin
                    errors++;
                    $display("%0t: fill expected 0 actual %h", $time, m_tdata[39:DW+2]);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;
    end

    task automatic send_query(input coord_t f[10]);
        logic [10*DW-1:0] d;
        for (int i = 0; i < 10; i++) d[DW*i +: DW] = f[i];
        while (gaps_on && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    task automatic test_directed();
        coord_t f[10];
        coord_t ext[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
        // nominal: unit square at the middle
        f = '{32'sh8000, 32'sh8000, 0, 32'sh10000, 0, 32'sh10000,
              0, 32'sh10000, 32'sh20000, 32'sh30000};
        send_query(f);
        // zero span on x, then on y
        f[3] = f[2];
        send_query(f);
        f[3] = 32'sh10000; f[5] = f[4];
        send_query(f);
        // reversed grid
        f = '{32'sh4000, 32'shc000, 32'sh10000, 0, 32'sh10000, 0,
              32'sh1234, -32'sh5678, 32'sh7fff, 32'sh100};
        send_query(f);
        // far extrapolation, clipping
        f = '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1, 0, 1,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
        send_query(f);
        f = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh8000_0000};
        send_query(f);
        for (int k = 0; k < 16; k++) begin
            for (int i = 0; i < 10; i++) f[i] = ext[(k + i * (k % 3 + 1)) % 4];
            send_query(f);
        end
    endtask

    task automatic test_grid_queries(input int n);
        coord_t f[10];
        int span;
        for (int k = 0; k < n; k++) begin
            gaps_on = !(k >= n / 3 && k < n / 2);
            span = $urandom_range(1, 1 << $urandom_range(0, 20));
            f[2] = coord_t'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            f[3] = ($urandom_range(1)) ? f[2] + span : f[2] - span;
            f[0] = f[2] + coord_t'($signed($urandom_range(0, 3 * span)) - span);
            span = $urandom_range(1, 1 << $urandom_range(0, 20));
            f[4] = coord_t'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            f[5] = ($urandom_range(1)) ? f[4] + span : f[4] - span;
            f[1] = f[4] + coord_t'($signed($urandom_range(0, 3 * span)) - span);
            for (int i = 6; i < 10; i++)
                f[i] = ($urandom_range(3) == 0) ? rand_coord()
                                                : coord_t'($signed($urandom) >>> 6);
            send_query(f);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_raw_queries(input int n);
        coord_t f[10];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 10; i++) f[i] = rand_coord();
            if ($urandom_range(9) == 0) f[3] = f[2];
            if ($urandom_range(9) == 0) f[5] = f[4];
            send_query(f);
        end
    endtask

    initial begin
        int waited;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_grid_queries(1300);
        test_raw_queries(500);
        s_tvalid <= 1'b0;
        waited = 0;
        while (blend_queue.size() != 0) @(posedge aclk);
        while (waited < LATENCY + 20) begin
            @(posedge aclk);
            waited++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
